FILE: src/aea_pkg.sv
// package for the expression alu: opcodes, payload structs, control bundles
// no dependencies
package aea_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CntW  = 6;

  localparam logic [3:0] OP_DIV  = 4'd0;
  localparam logic [3:0] OP_MOD  = 4'd1;
  localparam logic [3:0] OP_POW  = 4'd2;
  localparam logic [3:0] OP_SHL  = 4'd3;
  localparam logic [3:0] OP_SAR  = 4'd4;
  localparam logic [3:0] OP_SHR  = 4'd5;
  localparam logic [3:0] OP_NEG  = 4'd6;
  localparam logic [3:0] OP_HIGH = 4'd7;
  localparam logic [3:0] OP_LOW  = 4'd8;
  localparam logic [3:0] OP_BITW = 4'd9;
  localparam logic [3:0] OP_TZC  = 4'd10;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } aea_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               divide_by_zero;
  } aea_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // capture request, set up iteration
    logic step;    // one divide or power iteration
    logic finish;  // form the result
  } aea_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic iterative;  // loaded op needs the loop
    logic last;       // current step is the final one
  } aea_sts_t;

endpackage

FILE: src/assembler_expression_alu_core.sv
// channel   | dir | signals
// in_       | in  | in_valid, in_ready, in_data (aea_in_t)
// out_      | out | out_valid, out_ready, out_data (aea_out_t)
// div, mod and pow go from request to result through load, 32 steps, finish
// other ops go through load and finish; the 32-step shared divider/multiplier loop sets the rate
// a new request is taken only when the loop is idle and no result waits or it leaves
// rst_n is synchronous, active low; stalls on out_ready hold the result register
module assembler_expression_alu_core import aea_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  aea_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output aea_out_t out_data
);

  aea_cmd_t cmd;
  aea_sts_t sts;

  aea_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  aea_datapath u_dp (
    .clk, .req(in_data), .cmd, .sts, .res(out_data)
  );

endmodule

FILE: src/aea_datapath.sv
// datapath: operand registers, restoring divider, square-and-multiply, combinational quick ops
// depends on aea_pkg
module aea_datapath import aea_pkg::*; (
  input  logic     clk,
  input  aea_in_t  req,
  input  aea_cmd_t cmd,
  output aea_sts_t sts,
  output aea_out_t res
);

  logic [3:0]  op_r;
  logic [31:0] a_r, b_r;
  logic [31:0] rem_r, quo_r, dvs_r;   // divider: remainder, dividend/quotient, |divisor|
  logic [31:0] acc_r, base_r, exp_r;  // power
  logic [CntW-1:0] cnt_r;
  aea_out_t    res_r;
  aea_out_t    res_nxt;

  logic        neg_a, neg_b;
  logic [31:0] abs_a, abs_b;
  logic [32:0] trial;
  logic [31:0] rem_sh;
  logic [31:0] q_s, r_s, q_f, r_f;
  logic [31:0] quick;
  logic [31:0] lz, tz;
  logic signed [32:0] amt;

  always_comb begin
    abs_a = req.operand_a[31] ? 32'(-req.operand_a) : 32'(req.operand_a);
    abs_b = req.operand_b[31] ? 32'(-req.operand_b) : 32'(req.operand_b);
  end

  assign rem_sh = {rem_r[30:0], quo_r[31]};
  assign trial  = {1'b0, rem_sh} - {1'b0, dvs_r};

  assign sts.iterative = (op_r == OP_DIV) || (op_r == OP_MOD) || (op_r == OP_POW);
  assign sts.last      = (cnt_r == CntW'(DataW - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= req.op;
      a_r    <= req.operand_a;
      b_r    <= req.operand_b;
      rem_r  <= '0;
      quo_r  <= abs_a;
      dvs_r  <= abs_b;
      acc_r  <= 32'd1;
      base_r <= req.operand_a;
      exp_r  <= req.operand_b;
      cnt_r  <= '0;
    end else if (cmd.step) begin
      if (trial[32]) begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[30:0], 1'b0};
      end else begin
        rem_r <= trial[31:0];
        quo_r <= {quo_r[30:0], 1'b1};
      end
      if (exp_r[0]) acc_r <= 32'(acc_r * base_r);
      base_r <= 32'(base_r * base_r);
      exp_r  <= exp_r >> 1;
      cnt_r  <= cnt_r + CntW'(1);
    end
    if (cmd.finish) res_r <= res_nxt;
  end

  // floor adjust of truncated signed quotient and remainder
  always_comb begin
    neg_a = a_r[31];
    neg_b = b_r[31];
    q_s = (neg_a ^ neg_b) ? 32'(-quo_r) : quo_r;
    r_s = neg_a ? 32'(-rem_r) : rem_r;
    q_f = q_s;
    r_f = r_s;
    if ((r_s != '0) && (r_s[31] != neg_b)) begin
      q_f = q_s - 32'd1;
      r_f = r_s + b_r;
    end
  end

  always_comb begin
    lz = 32'd32;
    for (int i = 0; i < 32; i++) if (a_r[i]) lz = 32'(31 - i);
    tz = 32'd32;
    for (int i = 31; i >= 0; i--) if (a_r[i]) tz = 32'(i);
  end

  assign amt = 33'(signed'(b_r));

  always_comb begin
    quick = '0;
    case (op_r)
      OP_SHL: begin
        if (b_r == '0) quick = a_r;
        else if (a_r == '0 || amt >= 33'sd32) quick = '0;
        else if (amt < -33'sd31) quick = {32{a_r[31]}};
        else if (amt < 0) quick = 32'($signed(a_r) >>> 5'(-b_r));
        else quick = a_r << b_r[4:0];
      end
      OP_SAR: begin
        if (b_r == '0) quick = a_r;
        else if (a_r == '0 || amt < -33'sd31) quick = '0;
        else if (amt > 33'sd31) quick = {32{a_r[31]}};
        else if (amt < 0) quick = a_r << 5'(-b_r);
        else quick = 32'($signed(a_r) >>> b_r[4:0]);
      end
      OP_SHR: begin
        if (b_r == '0) quick = a_r;
        else if (a_r == '0 || amt < -33'sd31 || amt > 33'sd31) quick = '0;
        else if (amt < 0) quick = a_r << 5'(-b_r);
        else quick = a_r >> b_r[4:0];
      end
      OP_NEG:  quick = 32'(-a_r);
      OP_HIGH: quick = {24'd0, a_r[15:8]};
      OP_LOW:  quick = {24'd0, a_r[7:0]};
      OP_BITW: quick = 32'd32 - lz;
      OP_TZC:  quick = tz;
      default: quick = '0;
    endcase
  end

  always_comb begin
    res_nxt = '{result: quick, divide_by_zero: 1'b0};
    if (op_r == OP_DIV || op_r == OP_MOD) begin
      if (b_r == '0) res_nxt = '{result: '0, divide_by_zero: 1'b1};
      else res_nxt.result = (op_r == OP_DIV) ? q_f : r_f;
    end else if (op_r == OP_POW) begin
      res_nxt.result = acc_r;
    end
  end

  assign res = res_r;

endmodule

FILE: src/aea_ctrl.sv
// controller: idle / run / finish sequencing with held-result output handshake
// depends on aea_pkg
module aea_ctrl import aea_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  aea_sts_t sts,
  output aea_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;

  // new request allowed in idle when no result is held or the held result leaves
  assign in_ready  = (state_r == S_IDLE) && (!ovld_r || out_ready);
  assign out_valid = ovld_r;

  always_comb begin
    state_nxt  = state_r;
    ovld_nxt   = ovld_r && !out_ready;
    cmd        = '0;
    case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.load  = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.iterative) begin
          cmd.step = 1'b1;
          if (sts.last) state_nxt = S_FIN;
        end else begin
          cmd.finish = 1'b1;
          ovld_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        ovld_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !ovld_r) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load while busy");
  a_run_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_RUN) else $error("no run after load");

endmodule
